// ----- rtl/core/xs256_pkg.sv -----
`default_nettype none

package xs256_pkg;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

	// shift and rotate amounts
	localparam int unsigned MIX_SHIFT_0 = 30;
	localparam int unsigned MIX_SHIFT_1 = 27;
	localparam int unsigned MIX_SHIFT_2 = 31;
	localparam int unsigned OUT_ROT     = 23;
	localparam int unsigned XS_SHIFT    = 17;
	localparam int unsigned XS_ROT      = 45;
	localparam int unsigned FRAC_SHIFT  = 11;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned FRAC_W = 53;

	// request kinds on tuser
	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAMMA,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MIX,
		ST_DRAW
	} xs256_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/xoshiro256pp_random_generator.sv -----
`default_nettype none

// Channel   Dir  tdata                                         tuser
// s_axis    in   [63:0] seed_value                             [0] operation (0 seed, 1 draw)
// m_axis    out  [63:0] random_word, [116:64] uniform_fraction -
//
// A draw registers s0 + s3 as the request is taken, then does the output add and state update.
// A seed takes the request, then runs four splitmix64 rounds, each two 64-bit multiplies
// done as three 32x32 partial products on one shared multiplier, plus gamma and mix steps.
// Reset clears the state words, so draws before any seed give zero.
// A draw waits in its last cycle while a finished result is not yet taken.
module xoshiro256pp_random_generator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [63:0]  s_axis_tdata,   // [63:0] seed_value
	input  wire logic         s_axis_tuser,   // [0] operation
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [119:0]      m_axis_tdata    // [63:0] random_word, [116:64] uniform_fraction
);
	import xs256_pkg::*;

	xs256_state_t state_q, state_nxt;

	logic [63:0] s_q [4];
	logic [63:0] acc_q;
	logic [63:0] z_q;
	logic [63:0] prod_q;
	logic [63:0] sum_q;
	logic [1:0]  idx_q;
	logic        pass_q;
	logic        out_valid_q;
	logic [63:0] out_word_q;

	logic        in_fire;
	logic        out_free;
	logic        draw_fire;
	logic [63:0] mul_const;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] acc_next;
	logic [63:0] word;
	logic [63:0] t_shift;
	logic [63:0] ns2, ns3, ns1, ns0;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_nxt = (s_axis_tuser == OP_DRAW) ? ST_DRAW : ST_GAMMA;
				end
			end
			ST_GAMMA: state_nxt = ST_MUL0;
			ST_MUL0:  state_nxt = ST_MUL1;
			ST_MUL1:  state_nxt = ST_MUL2;
			ST_MUL2:  state_nxt = ST_MIX;
			ST_MIX: begin
				if (!pass_q) begin
					state_nxt = ST_MUL0;
				end else if (idx_q == 2'd3) begin
					state_nxt = ST_IDLE;
				end else begin
					state_nxt = ST_GAMMA;
				end
			end
			ST_DRAW: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs and multiplier operand select
	always_comb begin
		s_axis_tready = 1'b0;
		draw_fire     = 1'b0;
		mul_a         = z_q[31:0];
		mul_b         = mul_const[31:0];
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_MUL1: mul_b = mul_const[63:32];
			ST_MUL2: mul_a = z_q[63:32];
			ST_DRAW: draw_fire = out_free;
			default: ;
		endcase
	end

	// shared 32x32 multiplier
	assign mul_const = pass_q ? MIX_MUL_B : MIX_MUL_A;
	assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
	assign acc_next  = acc_q + GOLDEN_GAMMA;

	// xoshiro256++ output and transition
	assign word    = {sum_q[63-OUT_ROT:0], sum_q[63:64-OUT_ROT]} + s_q[0];
	assign t_shift = s_q[1] << XS_SHIFT;
	assign ns2     = s_q[2] ^ s_q[0];
	assign ns3     = s_q[3] ^ s_q[1];
	assign ns1     = s_q[1] ^ ns2;
	assign ns0     = s_q[0] ^ ns3;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 2'd0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				s_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (draw_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire && s_axis_tuser == OP_SEED) begin
				idx_q  <= 2'd0;
				pass_q <= 1'b0;
			end
			if (state_q == ST_MIX) begin
				pass_q <= !pass_q;
				if (pass_q) begin
					s_q[idx_q] <= prod_q ^ (prod_q >> MIX_SHIFT_2);
					idx_q      <= idx_q + 2'd1;
				end
			end
			if (draw_fire) begin
				s_q[0] <= ns0;
				s_q[1] <= ns1;
				s_q[2] <= ns2 ^ t_shift;
				s_q[3] <= {ns3[63-XS_ROT:0], ns3[63:64-XS_ROT]};
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_q <= s_axis_tdata;
			sum_q <= s_q[0] + s_q[3];
		end
		case (state_q)
			ST_GAMMA: begin
				acc_q <= acc_next;
				z_q   <= acc_next ^ (acc_next >> MIX_SHIFT_0);
			end
			ST_MUL0: prod_q <= mul_p;
			ST_MUL1: prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
			ST_MUL2: prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
			ST_MIX: begin
				if (!pass_q) begin
					z_q <= prod_q ^ (prod_q >> MIX_SHIFT_1);
				end
			end
			default: ;
		endcase
		if (draw_fire) begin
			out_word_q <= word;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_word_q[WORD_W-1:FRAC_SHIFT], out_word_q};

	// checks
	a_seed_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_axis_tuser == OP_SEED) |=> !$rose(m_axis_tvalid))
		else $error("seed request produced a result");

	a_result_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_DRAW)
		else $error("result appeared outside a draw");

	a_idx_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(idx_q) |-> ($past(state_q) == ST_MIX || $past(in_fire)))
		else $error("word index moved outside mix step");

	a_seed_ends_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX && pass_q && idx_q != 2'd3) |=> state_q == ST_GAMMA)
		else $error("seed sequence ended early");

endmodule

`default_nettype wire

// ----- sim/xoshiro_stream_checker.sv -----
`timescale 1ns / 100ps

// Watches both stream channels, keeps its own copy of the generator state
// and compares every result word against the predicted draw.
module xoshiro_stream_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [63:0]  s_axis_tdata,   // [63:0] seed_value
	input  wire logic         s_axis_tuser,   // [0] operation
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [119:0] m_axis_tdata,   // [63:0] random_word, [116:64] uniform_fraction
	output int                fail_count,
	output int                results_pending,
	output int                seeds_taken,
	output int                draws_taken,
	output int                words_checked
);
	import xs256_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [FRAC_W-1:0] fraction;
	} draw_result_t;

	logic [63:0]  gen_words [4];
	draw_result_t pending_draws [$];

	logic [63:0]  seed_acc;
	logic [63:0]  draw_word;
	logic [63:0]  shifted_s1;
	draw_result_t observed;
	draw_result_t predicted;

	// rotate amounts used here are never zero
	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amount);
		return (v << amount) | (v >> (WORD_W - amount));
	endfunction

	// splitmix64 finalizer
	function automatic logic [63:0] splitmix_mix(input logic [63:0] z);
		logic [63:0] m;
		m = (z ^ (z >> MIX_SHIFT_0)) * MIX_MUL_A;
		m = (m ^ (m >> MIX_SHIFT_1)) * MIX_MUL_B;
		return m ^ (m >> MIX_SHIFT_2);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				gen_words[i] = '0;
			pending_draws.delete();
			fail_count      = 0;
			seeds_taken     = 0;
			draws_taken     = 0;
			words_checked   = 0;
			results_pending <= 0;
		end else begin
			// result side: compare against the oldest predicted draw
			if (m_axis_tvalid && m_axis_tready) begin
				observed.word     = m_axis_tdata[63:0];
				observed.fraction = m_axis_tdata[116:64];
				if (pending_draws.size() == 0) begin
					$display("%0t: unexpected result, expected none, got word %h fraction %h",
						$time, observed.word, observed.fraction);
					fail_count++;
				end else begin
					predicted = pending_draws.pop_front();
					words_checked++;
					if (observed.word !== predicted.word) begin
						$display("%0t: random_word mismatch, expected %h, got %h",
							$time, predicted.word, observed.word);
						fail_count++;
					end
					if (observed.fraction !== predicted.fraction) begin
						$display("%0t: uniform_fraction mismatch, expected %h, got %h",
							$time, predicted.fraction, observed.fraction);
						fail_count++;
					end
				end
			end

			// request side: advance the predicted state
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == OP_SEED) begin
					seed_acc = s_axis_tdata;
					for (int i = 0; i < 4; i++) begin
						seed_acc     = seed_acc + GOLDEN_GAMMA;
						gen_words[i] = splitmix_mix(seed_acc);
					end
					seeds_taken++;
				end else begin
					draw_word    = rotl64(gen_words[0] + gen_words[3], OUT_ROT) + gen_words[0];
					shifted_s1   = gen_words[1] << XS_SHIFT;
					gen_words[2] = gen_words[2] ^ gen_words[0];
					gen_words[3] = gen_words[3] ^ gen_words[1];
					gen_words[1] = gen_words[1] ^ gen_words[2];
					gen_words[0] = gen_words[0] ^ gen_words[3];
					gen_words[2] = gen_words[2] ^ shifted_s1;
					gen_words[3] = rotl64(gen_words[3], XS_ROT);
					predicted.word     = draw_word;
					predicted.fraction = draw_word[WORD_W-1:FRAC_SHIFT];
					pending_draws.push_back(predicted);
					draws_taken++;
				end
			end

			results_pending <= pending_draws.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import xs256_pkg::*;

	localparam int RANDOM_REQUESTS = 450;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 40;   // covers a seed still in flight
	localparam int HOLD_OFF_CYCLES = 300;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata  = '0;
	logic         s_axis_tuser  = OP_DRAW;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [119:0] m_axis_tdata;

	int fail_count;
	int results_pending;
	int seeds_taken;
	int draws_taken;
	int words_checked;

	bit steady_sender    = 1'b0;
	bit hold_off_request = 1'b0;
	int idle_cycles      = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	xoshiro256pp_random_generator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	xoshiro_stream_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.fail_count     (fail_count),
		.results_pending(results_pending),
		.seeds_taken    (seeds_taken),
		.draws_taken    (draws_taken),
		.words_checked  (words_checked)
	);

	// offer one request, with a random gap first unless the sender runs steady
	task automatic drive_request(input logic op, input logic [63:0] value);
		int gap;
		gap = 0;
		if (!steady_sender) begin
			if ($urandom_range(0, 19) == 0)
				gap = $urandom_range(10, 30);
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// no progress on either channel for too long ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no request moved for %0d cycles", $time, STALL_LIMIT);
				$display("xoshiro256pp_random_generator test failed");
				$finish;
			end
		end
	end

	// result receiver: open stretches, short stalls, rare long stalls, one hold-off
	initial begin
		int span;
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_request = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b1;
				span = $urandom_range(20, 60);
				repeat (span) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				span = $urandom_range(1, 4);
				repeat (span) @(posedge clk);
				if ($urandom_range(0, 9) == 0)
					stall = $urandom_range(10, 40);
				else
					stall = $urandom_range(0, 3);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic        op;
		logic [63:0] value;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// draws from the reset state give zero, seed_value ignored
		drive_request(OP_DRAW, 64'h0);
		drive_request(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
		drive_request(OP_DRAW, {$urandom, $urandom});
		// seed extremes
		drive_request(OP_SEED, 64'h0);
		drive_request(OP_DRAW, 64'h0);
		drive_request(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
		drive_request(OP_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		drive_request(OP_DRAW, 64'h5555_5555_5555_5555);
		drive_request(OP_DRAW, 64'hAAAA_AAAA_AAAA_AAAA);
		// back-to-back reseed replaces the state
		drive_request(OP_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
		drive_request(OP_SEED, 64'h5555_5555_5555_5555);
		drive_request(OP_DRAW, 64'h0);
		drive_request(OP_DRAW, 64'h0);
		drive_request(OP_SEED, 64'h8000_0000_0000_0000);
		drive_request(OP_DRAW, 64'h0);
		drive_request(OP_SEED, 64'h1);
		drive_request(OP_DRAW, 64'h8000_0000_0000_0001);
		drive_request(OP_DRAW, 64'h1234_5678_9ABC_DEF0);
		drive_request(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
		// seed wraps the accumulator to zero on the first round
		drive_request(OP_SEED, 64'h0 - GOLDEN_GAMMA);
		drive_request(OP_DRAW, 64'h0);
		drive_request(OP_DRAW, 64'h0);

		// random traffic, mostly draws with occasional reseeds
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0)
				steady_sender = ($urandom_range(0, 3) == 0);
			if (n == 160) begin
				steady_sender    = 1'b1;
				hold_off_request = 1'b1;
			end
			op = ($urandom_range(0, 15) == 0) ? OP_SEED : OP_DRAW;
			case ($urandom_range(0, 9))
				0: value = 64'h0;
				1: value = 64'hFFFF_FFFF_FFFF_FFFF;
				default: value = {$urandom, $urandom};
			endcase
			drive_request(op, value);
		end
		s_axis_tvalid <= 1'b0;

		// let the checker see the last request, then drain
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d seed and %0d draw requests, %0d result words compared,",
			seeds_taken, draws_taken, words_checked);
		$display("including draws before seeding, reseeds and a long output hold-off.");
		if (fail_count == 0)
			$display("xoshiro256pp_random_generator test passed");
		else
			$display("xoshiro256pp_random_generator test failed");
		$finish;
	end

endmodule
